@@ sv/uepm_pkg.sv @@
`timescale 1ns / 1ps
// uepm_pkg: shared types, register indexes, codes and constants of the echo presence monitor
// no dependencies; imported by every module of the block

package uepm_pkg;

   // parameter defaults
   localparam int CHANNELS_DEF      = 3;
   localparam int HISTORY_DEPTH_DEF = 5;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GOOD            = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_GOOD            = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_ENABLE_DISTANCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_HOLD_SECONDS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE_US        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIBRATION_MODE    = 3'd5;

   localparam logic [11:0] MIN_GOOD_RST            = 12'd120;
   localparam logic [11:0] MAX_GOOD_RST            = 12'd150;
   localparam logic [11:0] LED_ENABLE_DISTANCE_RST = 12'd80;
   localparam logic [7:0]  LED_HOLD_SECONDS_RST    = 8'd30;
   localparam logic [15:0] MIN_PULSE_US_RST        = 16'd100;
   localparam logic        CALIBRATION_MODE_RST    = 1'b0;

   // field codes
   localparam logic       ACTION_EDGE  = 1'b0;
   localparam logic       ACTION_TICK  = 1'b1;
   localparam logic       LEVEL_RISING = 1'b1;
   localparam logic       KIND_MEASURE = 1'b0;
   localparam logic       KIND_LED_OFF = 1'b1;
   localparam logic [1:0] LED_OFF      = 2'b00;
   localparam logic [1:0] LED_RED      = 2'b01;
   localparam logic [1:0] LED_GREEN    = 2'b10;

   // distance scaling: d = floor(w * 16 / 58) = floor(w * 8 / 29)
   // saturates once w * 8 reaches 29 * 2^16
   localparam int          DIST_W      = 16;
   localparam logic [31:0] SAT_WIDTH   = 32'd237568;
   localparam int          SCALE_NUM_W = 21;
   localparam int          RECIP_SHIFT = 26;
   localparam logic [21:0] RECIP_29    = 22'd2314099;

   // moving average
   localparam int SUM_W             = 19;
   localparam int CNT_W             = 3;
   localparam int DIV_BITS_PER_STEP = 4;
   localparam int DIV_STEPS         = 5;
   localparam int DIV_NUM_W         = DIV_STEPS * DIV_BITS_PER_STEP;
   localparam int DIV_STEP_W        = 3;

   localparam int HOLD_W = 8;

   typedef struct packed {
      logic        action;
      logic [1:0]  channel;
      logic        echo_level;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        channel_out;
      logic [DIST_W-1:0] distance_x16;
      logic [DIST_W-1:0] average_x16;
      logic              present;
      logic              present_changed;
      logic [1:0]        led_code;
      logic              led_write;
      logic              show_distance;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic edge_eval;
      logic scale;
      logic update;
      logic div_step;
      logic finish_load;
      logic tick_update;
      logic walk_load;
      logic walk_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic ch_valid;
      logic rising;
      logic short_pulse;
      logic div_done;
      logic out_free;
      logic walk_hit;
      logic walk_done;
   } ctrl_status_type;

endpackage

@@ sv/ultrasonic_echo_presence_monitor.sv @@
`timescale 1ns / 1ps
// ultrasonic_echo_presence_monitor: top level, joins the controller and the datapath
// depends on uepm_pkg, uepm_ctrl and uepm_dpath
//
// One beat in carries either an echo edge of a channel or a one-second tick. A falling edge
// closes a pulse: its width (modulo 2^32, low two bits cleared) becomes a distance in
// sixteenths of a centimetre, saturating at 65535, and pulses no longer than min_pulse_us are
// dropped. Each channel averages its last HISTORY_DEPTH distances; presence is the average lying
// strictly inside (min_good, max_good) and is reported with a change flag and the LED drive.
// A distance below led_enable_distance starts a hold timer of led_hold_seconds ticks (zero means
// one); a tick that runs a timer out gives an LED-off beat, one per expired channel in channel
// order, with last set on the final one. The block works on one item at a time. A falling edge
// passes decode, edge, scale, update, the divider steps and finish; the average divider makes
// four quotient bits a cycle over 5 steps. Rising edges and short pulses end after the edge
// state, edges on absent channels after decode, a tick after its channel walk; every result beat
// also waits for rsp_ready. The output register lets a new item in while the last result beat is
// still waiting. Configuration must be written by the user through the csr port only while the
// block is idle; the block does not enforce it. The history store needs no clearing after reset.

module ultrasonic_echo_presence_monitor #(
   parameter int CHANNELS      = uepm_pkg::CHANNELS_DEF,
   parameter int HISTORY_DEPTH = uepm_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  uepm_pkg::req_type                req_data,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output uepm_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                             csr_we,
   input  logic [uepm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uepm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import uepm_pkg::*;

   // command and status between sequencer and datapath
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: decode, width, scale, update, divide, report; or tick and walk the channels
   uepm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: channel state, history store, scaler, divider and the output register
   uepm_dpath #(
      .CHANNELS      (CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a waiting result beat is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(cmd.finish_load || cmd.walk_load))
      else $error("result beat overwritten while stalled");

   // the sequencer is busy in the cycle after it takes a beat
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input beat taken while the previous one is still in work");

   // a measurement is always the only result of its edge
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_MEASURE) |-> rsp_data.last)
      else $error("measurement beat without last");

   // an led switch-off beat drives the leds dark
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_LED_OFF) |->
         (rsp_data.led_write && rsp_data.led_code == LED_OFF))
      else $error("led switch-off beat with wrong led drive");

endmodule

@@ sv/uepm_ctrl.sv @@
`timescale 1ns / 1ps
// uepm_ctrl: sequencing state machine of the echo presence monitor
// depends on uepm_pkg; drives the command struct of uepm_dpath

module uepm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  uepm_pkg::ctrl_status_type status,
   output uepm_pkg::ctrl_cmd_type    cmd
);
   import uepm_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_EDGE   = 9'b000000100,
      ST_SCALE  = 9'b000001000,
      ST_UPDATE = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_FINISH = 9'b001000000,
      ST_TICK   = 9'b010000000,
      ST_WALK   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_tick) begin
               state_in = ST_TICK;
            end else if (status.ch_valid) begin
               state_in = ST_EDGE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EDGE: begin
            cmd.edge_eval = 1'b1;
            if (status.rising || status.short_pulse) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_TICK: begin
            cmd.tick_update = 1'b1;
            state_in        = ST_WALK;
         end
         ST_WALK: begin
            // hold on an expired channel until the output register is free
            if (!status.walk_hit || status.out_free) begin
               cmd.walk_load = status.walk_hit;
               if (status.walk_done) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/uepm_dpath.sv @@
`timescale 1ns / 1ps
// uepm_dpath: channel state, history memory, scaler, average divider and output register
// depends on uepm_pkg; sequenced by uepm_ctrl through the command struct

module uepm_dpath #(
   parameter int CHANNELS      = uepm_pkg::CHANNELS_DEF,
   parameter int HISTORY_DEPTH = uepm_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  uepm_pkg::req_type                    req_data,
   input  logic                                 csr_we,
   input  logic [uepm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [uepm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  uepm_pkg::ctrl_cmd_type               cmd,
   output uepm_pkg::ctrl_status_type            status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output uepm_pkg::rsp_type                    rsp_data
);
   import uepm_pkg::*;

   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // configuration
   logic [11:0]       min_good_ff, min_good_in;
   logic [11:0]       max_good_ff, max_good_in;
   logic [11:0]       led_en_ff, led_en_in;
   logic [HOLD_W-1:0] led_hold_ff, led_hold_in;
   logic [15:0]       min_pulse_ff, min_pulse_in;
   logic              cal_mode_ff, cal_mode_in;

   // per-channel state
   logic [31:0]       pulse_start_ff [CHANNELS];
   logic [31:0]       pulse_start_in [CHANNELS];
   logic [SUM_W-1:0]  sum_ff [CHANNELS];
   logic [SUM_W-1:0]  sum_in [CHANNELS];
   logic [CNT_W-1:0]  count_ff [CHANNELS];
   logic [CNT_W-1:0]  count_in [CHANNELS];
   logic [PTR_W-1:0]  ptr_ff [CHANNELS];
   logic [PTR_W-1:0]  ptr_in [CHANNELS];
   logic [HOLD_W-1:0] countdown_ff [CHANNELS];
   logic [HOLD_W-1:0] countdown_in [CHANNELS];
   logic [CHANNELS-1:0] led_on_ff, led_on_in;
   logic [CHANNELS-1:0] last_present_ff, last_present_in;

   // working registers
   req_type            in_ff, in_in;
   logic [31:0]        w_ff, w_in;
   logic [DIST_W-1:0]  d_ff, d_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [DIST_W-1:0]  hist_rd_ff;
   logic [DIV_NUM_W-1:0]  div_num_ff, div_num_in;
   logic [CNT_W-1:0]      div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]      div_den_ff, div_den_in;
   logic [DIV_STEP_W-1:0] div_step_ff, div_step_in;
   logic [CHANNELS-1:0]   mask_ff, mask_in;
   logic [CH_IDX_W-1:0]   walk_idx_ff, walk_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [DIST_W-1:0] hist_mem [MEM_DEPTH];

   // combinational helpers
   logic [CH_IDX_W-1:0]    ch_idx;
   logic [31:0]            width;
   logic [PTR_W-1:0]       p_eff;
   logic [PTR_W-1:0]       p_next;
   logic [ADDR_W-1:0]      slot;
   logic [SCALE_NUM_W+21:0] scale_prod;
   logic [DIV_NUM_W-1:0]   div_num_step;
   logic [CNT_W-1:0]       div_rem_step;
   logic                   walk_last;

   assign ch_idx = in_ff.channel[CH_IDX_W-1:0];
   assign width  = in_ff.time_us - pulse_start_ff[ch_idx];

   // ring pointer, clamped into the history depth
   always_comb begin
      logic [PTR_W:0] p_wide;
      logic [PTR_W:0] p_inc;
      p_wide = {1'b0, ptr_ff[ch_idx]};
      if (p_wide >= (PTR_W+1)'(HISTORY_DEPTH)) begin
         p_wide = '0;
      end
      p_inc = p_wide + (PTR_W+1)'(1);
      p_eff = p_wide[PTR_W-1:0];
      if (p_inc >= (PTR_W+1)'(HISTORY_DEPTH)) begin
         p_next = '0;
      end else begin
         p_next = p_inc[PTR_W-1:0];
      end
   end

   assign slot = ADDR_W'(int'(ch_idx) * HISTORY_DEPTH + int'(p_eff));

   assign scale_prod = {w_ff[SCALE_NUM_W-4:0], 3'b000} * RECIP_29;

   // radix-16 restoring step: four quotient bits a cycle, divisor is the sample count
   always_comb begin
      logic [DIV_NUM_W-1:0] num;
      logic [CNT_W-1:0]     rem;
      logic [CNT_W:0]       r4;
      num = div_num_ff;
      rem = div_rem_ff;
      r4  = '0;
      for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
         r4 = {rem, num[DIV_NUM_W-1]};
         if (r4 >= {1'b0, div_den_ff}) begin
            rem = CNT_W'(r4 - {1'b0, div_den_ff});
            num = {num[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem = r4[CNT_W-1:0];
            num = {num[DIV_NUM_W-2:0], 1'b0};
         end
      end
      div_num_step = num;
      div_rem_step = rem;
   end

   // last expiring channel of a tick
   always_comb begin
      walk_last = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         if ((i > int'(walk_idx_ff)) && mask_ff[i]) begin
            walk_last = 1'b0;
         end
      end
   end

   always_comb begin
      status.is_tick     = (in_ff.action == ACTION_TICK);
      status.ch_valid    = (int'(in_ff.channel) < CHANNELS);
      status.rising      = (in_ff.echo_level == LEVEL_RISING);
      status.short_pulse = (width <= {16'h0000, min_pulse_ff});
      status.div_done    = (div_step_ff == DIV_STEP_W'(DIV_STEPS - 1));
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.walk_hit    = mask_ff[walk_idx_ff];
      status.walk_done   = (walk_idx_ff == CH_IDX_W'(CHANNELS - 1));
   end

   always_comb begin
      logic                 full;
      logic [SUM_W-1:0]     sum_new;
      logic [CNT_W-1:0]     cnt_new;
      logic [SUM_W-1:0]     lo_bound;
      logic [SUM_W-1:0]     hi_bound;
      logic                 pres;

      min_good_in  = min_good_ff;
      max_good_in  = max_good_ff;
      led_en_in    = led_en_ff;
      led_hold_in  = led_hold_ff;
      min_pulse_in = min_pulse_ff;
      cal_mode_in  = cal_mode_ff;

      pulse_start_in  = pulse_start_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      countdown_in    = countdown_ff;
      led_on_in       = led_on_ff;
      last_present_in = last_present_ff;

      in_in        = in_ff;
      w_in         = w_ff;
      d_in         = d_ff;
      slot_in      = slot_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_step_in  = div_step_ff;
      mask_in      = mask_ff;
      walk_idx_in  = walk_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      full     = (count_ff[ch_idx] >= CNT_W'(HISTORY_DEPTH));
      sum_new  = sum_ff[ch_idx] - (full ? SUM_W'(hist_rd_ff) : '0) + SUM_W'(d_ff);
      cnt_new  = full ? CNT_W'(HISTORY_DEPTH) : count_ff[ch_idx] + CNT_W'(1);
      lo_bound = SUM_W'({min_good_ff, 4'b0000}) * SUM_W'(count_ff[ch_idx]);
      hi_bound = SUM_W'({max_good_ff, 4'b0000}) * SUM_W'(count_ff[ch_idx]);
      pres     = (sum_ff[ch_idx] > lo_bound) && (sum_ff[ch_idx] < hi_bound);

      if (csr_we) begin
         case (csr_index)
            CSR_MIN_GOOD:            min_good_in  = csr_wdata[11:0];
            CSR_MAX_GOOD:            max_good_in  = csr_wdata[11:0];
            CSR_LED_ENABLE_DISTANCE: led_en_in    = csr_wdata[11:0];
            CSR_LED_HOLD_SECONDS:    led_hold_in  = csr_wdata[HOLD_W-1:0];
            CSR_MIN_PULSE_US:        min_pulse_in = csr_wdata[15:0];
            CSR_CALIBRATION_MODE:    cal_mode_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         in_in = req_data;
      end

      if (cmd.edge_eval) begin
         if (status.rising) begin
            pulse_start_in[ch_idx] = in_ff.time_us;
         end
         w_in    = {width[31:2], 2'b00};
         slot_in = slot;
      end

      if (cmd.scale) begin
         if (w_ff >= SAT_WIDTH) begin
            d_in = '1;
         end else begin
            d_in = scale_prod[RECIP_SHIFT +: DIST_W];
         end
      end

      if (cmd.update) begin
         sum_in[ch_idx]   = sum_new;
         count_in[ch_idx] = cnt_new;
         ptr_in[ch_idx]   = p_next;
         if ((d_ff < {led_en_ff, 4'b0000}) && (countdown_ff[ch_idx] == '0)) begin
            countdown_in[ch_idx] = (led_hold_ff == '0) ? HOLD_W'(1) : led_hold_ff;
            led_on_in[ch_idx]    = 1'b1;
         end
         div_num_in  = DIV_NUM_W'(sum_new);
         div_rem_in  = '0;
         div_den_in  = cnt_new;
         div_step_in = '0;
      end

      if (cmd.div_step) begin
         div_num_in  = div_num_step;
         div_rem_in  = div_rem_step;
         div_step_in = div_step_ff + DIV_STEP_W'(1);
      end

      if (cmd.finish_load) begin
         last_present_in[ch_idx]     = pres;
         rsp_valid_in                = 1'b1;
         rsp_data_in.kind            = KIND_MEASURE;
         rsp_data_in.channel_out     = in_ff.channel;
         rsp_data_in.distance_x16    = d_ff;
         rsp_data_in.average_x16     = div_num_ff[DIST_W-1:0];
         rsp_data_in.present         = pres;
         rsp_data_in.present_changed = (pres != last_present_ff[ch_idx]);
         rsp_data_in.led_write       = led_on_ff[ch_idx];
         rsp_data_in.led_code        = led_on_ff[ch_idx] ? (pres ? LED_GREEN : LED_RED) : LED_OFF;
         rsp_data_in.show_distance   = cal_mode_ff;
         rsp_data_in.last            = 1'b1;
      end

      if (cmd.tick_update) begin
         for (int i = 0; i < CHANNELS; i++) begin
            mask_in[i] = 1'b0;
            if (countdown_ff[i] != '0) begin
               countdown_in[i] = countdown_ff[i] - HOLD_W'(1);
               if (countdown_ff[i] == HOLD_W'(1)) begin
                  led_on_in[i] = 1'b0;
                  mask_in[i]   = 1'b1;
               end
            end
         end
         walk_idx_in = '0;
      end

      if (cmd.walk_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.kind            = KIND_LED_OFF;
         rsp_data_in.channel_out     = 2'(walk_idx_ff);
         rsp_data_in.distance_x16    = '0;
         rsp_data_in.average_x16     = '0;
         rsp_data_in.present         = 1'b0;
         rsp_data_in.present_changed = 1'b0;
         rsp_data_in.led_code        = LED_OFF;
         rsp_data_in.led_write       = 1'b1;
         rsp_data_in.show_distance   = 1'b0;
         rsp_data_in.last            = walk_last;
      end

      if (cmd.walk_step) begin
         walk_idx_in = walk_idx_ff + CH_IDX_W'(1);
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_good_ff     <= MIN_GOOD_RST;
         max_good_ff     <= MAX_GOOD_RST;
         led_en_ff       <= LED_ENABLE_DISTANCE_RST;
         led_hold_ff     <= LED_HOLD_SECONDS_RST;
         min_pulse_ff    <= MIN_PULSE_US_RST;
         cal_mode_ff     <= CALIBRATION_MODE_RST;
         for (int i = 0; i < CHANNELS; i++) begin
            pulse_start_ff[i] <= '0;
            sum_ff[i]         <= '0;
            count_ff[i]       <= '0;
            ptr_ff[i]         <= '0;
            countdown_ff[i]   <= '0;
         end
         led_on_ff       <= '0;
         last_present_ff <= '0;
         div_step_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         min_good_ff     <= min_good_in;
         max_good_ff     <= max_good_in;
         led_en_ff       <= led_en_in;
         led_hold_ff     <= led_hold_in;
         min_pulse_ff    <= min_pulse_in;
         cal_mode_ff     <= cal_mode_in;
         pulse_start_ff  <= pulse_start_in;
         sum_ff          <= sum_in;
         count_ff        <= count_in;
         ptr_ff          <= ptr_in;
         countdown_ff    <= countdown_in;
         led_on_ff       <= led_on_in;
         last_present_ff <= last_present_in;
         div_step_ff     <= div_step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      w_ff        <= w_in;
      d_ff        <= d_in;
      slot_ff     <= slot_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      mask_ff     <= mask_in;
      walk_idx_ff <= walk_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // shared history store, one ring of HISTORY_DEPTH entries per channel
   always_ff @(posedge clock) begin
      if (cmd.edge_eval) begin
         hist_rd_ff <= hist_mem[slot];
      end
      if (cmd.update) begin
         hist_mem[slot_ff] <= d_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
